// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/etr_pkg.sv -----
// Shared constants and helpers of the engine tachometer speed unit.
`default_nettype none
package etr_pkg;

  localparam int MAX_TRIGGERS = 8;
  localparam int RING_DEPTH   = 2 * MAX_TRIGGERS;
  localparam int POS_W        = $clog2(RING_DEPTH);
  localparam int LEN_W        = $clog2(RING_DEPTH + 1);

  localparam int TIME_W  = 32;
  localparam int SPEED_W = 15;
  localparam int TRIG_W  = 4;
  localparam int ADDR_W  = 4;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  localparam logic [1:0] REG_TRIGGERS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  localparam logic [TRIG_W-1:0] TRIGGERS_RESET = 4'd1;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 32'd1000000;
  localparam logic [TIME_W-1:0] SCALE_RESET    = 32'd120000000;

  // ring length: twice the clamped trigger count
  function automatic logic [LEN_W-1:0] ring_len(input logic [TRIG_W-1:0] trig);
    logic [LEN_W-1:0] t;
    if (trig == '0) begin
      t = LEN_W'(1);
    end else if (32'(trig) > MAX_TRIGGERS) begin
      t = LEN_W'(MAX_TRIGGERS);
    end else begin
      t = LEN_W'(trig);
    end
    return LEN_W'(t << 1);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/etr_hist_ram.sv -----
// Edge history memory: one write and one registered read per cycle, zero until written.
`default_nettype none
module etr_hist_ram
  import etr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [POS_W-1:0]  waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [POS_W-1:0]  raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0]     mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] written;
  logic [TIME_W-1:0]     rword;
  logic                  rvalid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rword <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= written[raddr];
      end
    end
  end

  assign rdata = rvalid ? rword : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/etr_divider.sv -----
// Restoring bit-serial 32-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module etr_divider
  import etr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic      [TIME_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   diff;

  assign rem_sh = {rem, quotient[TIME_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!diff[TIME_W]) begin
        rem <= diff[TIME_W-1:0];
      end else begin
        rem <= rem_sh[TIME_W-1:0];
      end
      quotient <= {quotient[TIME_W-2:0], ~diff[TIME_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(TIME_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/engine_tachometer_rpm_unit.sv -----
// Top level of the engine tachometer speed unit.
//
// Input channel (op, now_us; in_valid/in_stall): op=1 records a trigger edge
// at now_us, op=0 only reads the speed. Every item yields one speed item on
// the output channel (speed; out_valid/out_stall).
// An item whose oldest edge has timed out, or whose span is zero, passes
// through ST_READ, ST_EVAL and ST_DONE before out_valid rises; otherwise it
// also waits in ST_DIV for the 32-step bit-serial divider. The unit works on
// one item at a time and takes no new item until the last is through; in_stall is high while busy.
// The result sits in an output register: a stalled receiver holds speed
// steady while the next item is already accepted and processed; the unit
// waits only when a second result is ready before the first is taken.
// Configuration goes over an APB-style port: triggers_per_rev at 0x0,
// timeout_us at 0x4, scale_numerator at 0x8; pready is always high.
// Reset (synchronous, active high) clears the edge history, latest edge time
// and ring position to zero and restores register defaults; no clearing pass.
`default_nettype none
module engine_tachometer_rpm_unit
  import etr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [TIME_W-1:0]  now_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [SPEED_W-1:0] speed,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state;
  logic [TRIG_W-1:0]  triggers_per_rev;
  logic [TIME_W-1:0]  timeout_us;
  logic [TIME_W-1:0]  scale_numerator;
  logic [TIME_W-1:0]  latest_edge;
  logic [POS_W-1:0]   ring_position;
  logic [POS_W-1:0]   ring_position_next;
  logic [TIME_W-1:0]  now_q;
  logic [SPEED_W-1:0] result;

  logic               accept;
  logic               cfg_write;
  logic [LEN_W-1:0]   pos_inc;
  logic               ram_we;
  logic               ram_re;
  logic [TIME_W-1:0]  oldest;
  logic [TIME_W-1:0]  age;
  logic [TIME_W-1:0]  span;
  logic               div_start;
  logic               div_done;
  logic [TIME_W-1:0]  quotient;
  logic               out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      triggers_per_rev <= TRIGGERS_RESET;
      timeout_us       <= TIMEOUT_RESET;
      scale_numerator  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TRIGGERS: triggers_per_rev <= pwdata[TRIG_W-1:0];
        REG_TIMEOUT:  timeout_us       <= pwdata;
        REG_SCALE:    scale_numerator  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TRIGGERS: prdata = {{(32-TRIG_W){1'b0}}, triggers_per_rev};
      REG_TIMEOUT:  prdata = timeout_us;
      REG_SCALE:    prdata = scale_numerator;
      default:      prdata = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pos_inc = LEN_W'(ring_position) + LEN_W'(1);
  assign ring_position_next =
    (pos_inc >= ring_len(triggers_per_rev)) ? '0 : pos_inc[POS_W-1:0];

  assign ram_we = accept && op;
  assign ram_re = (state == ST_READ);

  etr_hist_ram u_hist (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ring_position),
    .wdata (latest_edge),
    .re    (ram_re),
    .raddr (ring_position),
    .rdata (oldest)
  );

  assign age  = now_q - oldest;
  assign span = latest_edge - oldest;
  assign div_start = (state == ST_EVAL) && (age < timeout_us) && (span != '0);

  etr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scale_numerator),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      latest_edge   <= '0;
      ring_position <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op) begin
              latest_edge   <= now_us;
              ring_position <= ring_position_next;
            end
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a new result may replace the one taken in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= now_us;
    end
    if (state == ST_EVAL) begin
      if (age >= timeout_us) begin
        result <= '0;
      end else if (span == '0) begin
        result <= SPEED_MAX;
      end
    end
    if ((state == ST_DIV) && div_done) begin
      if (quotient > TIME_W'(SPEED_MAX)) begin
        result <= SPEED_MAX;
      end else begin
        result <= quotient[SPEED_W-1:0];
      end
    end
    if ((state == ST_DONE) && out_free) begin
      speed <= result;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/etr_checker.sv -----
// Port-level checker for the engine tachometer speed unit, with its bind.
`default_nettype none
`include "assert_macros.svh"
module etr_checker
  import etr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [SPEED_W-1:0] speed,
  input wire logic               pready
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_speed_hold, clk, rst, out_valid && out_stall, $stable(speed))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall && pready, in_stall)
  `ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))
  `ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)

endmodule

bind engine_tachometer_rpm_unit etr_checker u_etr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .speed     (speed),
  .pready    (pready)
);
`default_nettype wire

// ----- bench/engine_tachometer_rpm_unit_tb.sv -----
// Self-checking testbench for the engine tachometer speed unit.
module engine_tachometer_rpm_unit_tb;
  import etr_pkg::*;

  localparam int LIMIT       = 1000000;
  localparam int SETTLE      = 40;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 114;
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  class tach_scoreboard;
    logic [TRIG_W-1:0]  trig;
    logic [TIME_W-1:0]  timeout;
    logic [TIME_W-1:0]  scale;
    logic [TIME_W-1:0]  last_edge;
    logic [TIME_W-1:0]  hist [RING_DEPTH];
    logic [POS_W-1:0]   pos;
    logic [SPEED_W-1:0] speeds_due [$];
    int                 errors;

    function new();
      trig      = TRIGGERS_RESET;
      timeout   = TIMEOUT_RESET;
      scale     = SCALE_RESET;
      last_edge = '0;
      pos       = '0;
      errors    = 0;
      foreach (hist[i]) hist[i] = '0;
    endfunction

    function void set_reg(logic [ADDR_W-3:0] idx, logic [31:0] v);
      case (idx)
        REG_TRIGGERS: trig = v[TRIG_W-1:0];
        REG_TIMEOUT:  timeout = v;
        REG_SCALE:    scale = v;
        default: ;
      endcase
    endfunction

    function int unsigned ring_size();
      int unsigned t;
      t = 32'(trig);
      if (t < 1) t = 1;
      if (t > MAX_TRIGGERS) t = MAX_TRIGGERS;
      return 2 * t;
    endfunction

    // edge push, then speed from oldest entry to latest edge, zero once timed out
    function void log_item(logic is_edge, logic [TIME_W-1:0] now_t);
      logic [TIME_W-1:0]  oldest;
      logic [TIME_W-1:0]  span;
      logic [TIME_W-1:0]  quo;
      int unsigned        nxt;
      logic [SPEED_W-1:0] s;
      if (is_edge) begin
        hist[pos] = last_edge;
        last_edge = now_t;
        nxt = pos + 1;
        pos = (nxt >= ring_size()) ? '0 : POS_W'(nxt);
      end
      oldest = hist[pos];
      if (TIME_W'(now_t - oldest) >= timeout) begin
        s = '0;
      end else begin
        span = last_edge - oldest;
        if (span == '0) begin
          s = SPEED_MAX;
        end else begin
          quo = scale / span;
          s = (quo > TIME_W'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];
        end
      end
      speeds_due.push_back(s);
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_speed(input logic [SPEED_W-1:0] got);
      logic [SPEED_W-1:0] want;
      if (speeds_due.size() == 0) begin
        report($sformatf("speed %0d with no item outstanding", got));
      end else begin
        want = speeds_due.pop_front();
        if (got !== want) report($sformatf("speed got %0d want %0d", got, want));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [TIME_W-1:0]  now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SPEED_W-1:0] speed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  tach_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  engine_tachometer_rpm_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .now_us(now_us),
    .out_valid(out_valid), .out_stall(out_stall), .speed(speed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.log_item(op, now_us);
      if (out_valid && !out_stall) sb.check_speed(speed);
    end
  end

  // receiver: free, light, heavy and long-stretch stall modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((stall_tick % 48) < 40);
    endcase
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(input logic is_edge, input logic [TIME_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= is_edge;
    now_us <= ts;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.speeds_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(addr[ADDR_W-1:2], data);
  endtask

  task automatic load_config(input logic [31:0] trig_w, input logic [31:0] tmo,
                             input logic [31:0] scl);
    wait_idle();
    apb_write({REG_TRIGGERS, 2'b00}, trig_w);
    apb_write({REG_TIMEOUT, 2'b00}, tmo);
    apb_write({REG_SCALE, 2'b00}, scl);
  endtask

  // regular edge train with reads between, plus timeouts and noise
  task automatic run_phase(input int n);
    int unsigned       period;
    int unsigned       r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] last;
    case ($urandom_range(0, 4))
      0: period = $urandom_range(50, 2000);
      1: period = $urandom_range(2000, 60000);
      2: period = $urandom_range(60000, 600000);
      3: period = $urandom_range(0, 3);
      default: period = $urandom_range(400, 20000);
    endcase
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000000) : $urandom;
    last = t;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        t = last + period - period / 16 + $urandom_range(0, period / 8);
        last = t;
        push_item(1'b1, t);
      end else if (r < 85) begin
        t = last + $urandom_range(0, period);
        push_item(1'b0, t);
      end else if (r < 92) begin
        t = last + $urandom_range(500000, 6000000);
        if ($urandom_range(0, 1) == 0) last = t;
        push_item(t == last, t);
      end else begin
        push_item(1'($urandom_range(0, 1)), $urandom);
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_item(1'b0, 32'h0000_0000);
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b1, 32'd1000);
    push_item(1'b0, 32'd1500);
    push_item(1'b1, 32'd3000);
    push_item(1'b1, 32'd10000);
    push_item(1'b0, 32'd20000);
    push_item(1'b1, 32'd40000);
    push_item(1'b1, 32'd5000000);
    push_item(1'b1, 32'd5000000);
    push_item(1'b1, 32'd5000000);
    push_item(1'b0, 32'd5000001);
    push_item(1'b1, 32'hFFFF_FFF0);
    push_item(1'b1, 32'h0000_0010);
    push_item(1'b0, 32'h0000_0020);
    push_item(1'b0, 32'h8000_0000);
    push_item(1'b1, 32'hAAAA_5555);
    push_item(1'b0, 32'h5555_AAAA);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(32'd1, 32'd1000000, 32'd120000000);
        1: load_config(32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_config(32'hFFFF_FFF0, 32'd3000000, 32'd1);
        3: load_config(32'd15, 32'd2000000, 32'd2000000);
        4: begin
          load_config(32'd3, 32'd0, 32'd120000000);
          apb_write(UNMAPPED_ADDR, $urandom);
        end
        5: load_config(32'd2, 32'd1, 32'd0);
        6: load_config(32'd1, 32'd1000000, 32'd120000000);
        default: load_config($urandom,
                             ($urandom_range(0, 1) == 0) ? $urandom
                                                         : $urandom_range(100000, 5000000),
                             ($urandom_range(0, 2) == 0) ? 32'd120000000 :
                             ($urandom_range(0, 1) == 0) ? 32'd2000000 : $urandom);
      endcase
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
